[hw/rtl/yuyv2rgb_pkg.sv]
// Types and constants for the YUYV 4:2:2 to RGB888 pixel-pair converter.
// No dependencies.
package yuyv2rgb_pkg;

    // Q16 chroma coefficients
    localparam logic signed [17:0] K_R_V = 18'sd89831;
    localparam logic signed [17:0] K_G_V = 18'sd45744;
    localparam logic signed [17:0] K_G_U = 18'sd22127;
    localparam logic signed [17:0] K_B_U = 18'sd113538;

    localparam logic [7:0] CHROMA_MID = 8'd128;
    localparam int         FRAC_BITS  = 16;
    localparam int         GAIN_SHIFT = 8;
    localparam logic [8:0] GAIN_RESET = 9'd220;

    // word index of the gain register
    localparam logic REG_GAIN = 1'b0;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end_in;
    } t_yuyv_item;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       frame_end_out;
    } t_rgb_item;

endpackage

[hw/rtl/yuyv_to_rgb_converter.sv]
// YUYV 4:2:2 to RGB888 pixel-pair converter, top level.
// Depends on yuyv2rgb_pkg.
//
//  channel | signals                              | carries
//  --------+--------------------------------------+---------------------------
//  in      | i_in_valid, o_in_ready, i_in_data    | one YUYV word per item
//  out     | o_out_valid, i_out_ready, o_out_data | two RGB pixels per item
//  cfg     | psel, penable, pwrite, paddr, pwdata | output_gain at word 0
//
// Three register stages: chroma products, floor and clamp, gain multiply
// (the last one is the output register). One item per cycle sustained while
// i_out_ready holds. Reset clears the stage valid bits and loads gain 220.
// A stall at the output holds only the stages that are full; empty stages
// behind it keep accepting, so no item is lost or repeated.
module yuyv_to_rgb_converter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  yuyv2rgb_pkg::t_yuyv_item i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output yuyv2rgb_pkg::t_rgb_item  o_out_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    import yuyv2rgb_pkg::*;

    // ---------------- configuration ----------------
    logic [8:0] r_gain;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GAIN);
    assign prdata = (paddr[2] == REG_GAIN) ? {23'd0, r_gain} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
        end else if (cfg_wr) begin
            r_gain <= pwdata[8:0];
        end
    end

    // ---------------- flow control ----------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3        = !r_v3 || i_out_ready;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // ---------------- stage 1: chroma products ----------------
    logic signed [8:0]  du, dv;
    logic signed [26:0] n_p_rv, n_p_gv, n_p_gu, n_p_bu;
    logic signed [26:0] r_p_rv, r_p_gv, r_p_gu, r_p_bu;
    logic [7:0]         r_y0, r_y1;
    logic               r_fe1;

    assign du = $signed({1'b0, i_in_data.chroma_blue}) - $signed({1'b0, CHROMA_MID});
    assign dv = $signed({1'b0, i_in_data.chroma_red}) - $signed({1'b0, CHROMA_MID});

    // operands sign-extended to the product width before multiplying
    always_comb begin
        n_p_rv = 27'(dv) * 27'(K_R_V);
        n_p_gv = 27'(dv) * 27'(K_G_V);
        n_p_gu = 27'(du) * 27'(K_G_U);
        n_p_bu = 27'(du) * 27'(K_B_U);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_p_rv <= n_p_rv;
            r_p_gv <= n_p_gv;
            r_p_gu <= n_p_gu;
            r_p_bu <= n_p_bu;
            r_y0   <= i_in_data.luma_first;
            r_y1   <= i_in_data.luma_second;
            r_fe1  <= i_in_data.frame_end_in;
        end
    end

    // ---------------- stage 2: sum, floor, clamp ----------------
    function automatic logic [7:0] clamp_q16(input logic signed [26:0] q);
        logic signed [10:0] f;
        logic [7:0]         c;
        begin
            f = q[26:FRAC_BITS];    // arithmetic floor
            if (f[10])
                c = 8'd0;
            else if (|f[9:8])
                c = 8'hFF;
            else
                c = f[7:0];
            return c;
        end
    endfunction

    logic signed [26:0] yq0, yq1;
    logic [7:0]         n_c[6];
    logic [7:0]         r_c[6];
    logic               r_fe2;

    assign yq0 = $signed({3'd0, r_y0, 16'd0});
    assign yq1 = $signed({3'd0, r_y1, 16'd0});

    always_comb begin
        n_c[0] = clamp_q16(yq0 + r_p_rv);
        n_c[1] = clamp_q16(yq0 - r_p_gv - r_p_gu);
        n_c[2] = clamp_q16(yq0 + r_p_bu);
        n_c[3] = clamp_q16(yq1 + r_p_rv);
        n_c[4] = clamp_q16(yq1 - r_p_gv - r_p_gu);
        n_c[5] = clamp_q16(yq1 + r_p_bu);
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int k = 0; k < 6; k++) r_c[k] <= n_c[k];
            r_fe2 <= r_fe1;
        end
    end

    // ---------------- stage 3: gain and saturate ----------------
    function automatic logic [7:0] apply_gain(input logic [7:0] c, input logic [8:0] g);
        logic [16:0] p;
        logic [8:0]  s;
        begin
            p = {9'd0, c} * {8'd0, g};
            s = p[16:GAIN_SHIFT];
            return s[8] ? 8'hFF : s[7:0];
        end
    endfunction

    t_rgb_item n_out, r_out;

    always_comb begin
        n_out.red_first     = apply_gain(r_c[0], r_gain);
        n_out.green_first   = apply_gain(r_c[1], r_gain);
        n_out.blue_first    = apply_gain(r_c[2], r_gain);
        n_out.red_second    = apply_gain(r_c[3], r_gain);
        n_out.green_second  = apply_gain(r_c[4], r_gain);
        n_out.blue_second   = apply_gain(r_c[5], r_gain);
        n_out.frame_end_out = r_fe2;
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // input side only backs up when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && !i_out_ready))
        else $error("input stalled while pipeline has room");

    a_gain_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_gain == $past(pwdata[8:0])))
        else $error("gain register write lost");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");
`endif

endmodule
